### rtl/core/clr_pkg.sv
// Shared constants, types and helpers for the clipped line rasteriser.
package clr_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = $clog2(MAX_DIM) + 1;
    localparam int POS_BITS   = 12;
    localparam int COLOR_BITS = 24;
    // Clipped coordinates are held within +-2^30.
    localparam int CW         = 32;
    localparam int AW         = CW + 1;
    localparam int PW         = 2 * AW + 2;
    localparam int QW         = PW - 1;
    localparam int CNT_BITS   = $clog2(QW + 1);
    localparam int ERR_BITS   = 16;
    localparam int SNM_BITS   = 15;

    localparam logic [CW-1:0] LIMIT_MAG = CW'(1) << 30;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic REG_CANVAS_WIDTH  = 1'b0;
    localparam logic REG_CANVAS_HEIGHT = 1'b1;

    localparam logic [DIM_BITS-1:0] RESET_WIDTH  = DIM_BITS'(1024);
    localparam logic [DIM_BITS-1:0] RESET_HEIGHT = DIM_BITS'(768);

    localparam logic [3:0] LAST_CLIP = 4'hF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_CLIP_EVAL,
        ST_CLIP_WAIT,
        ST_POST,
        ST_SETUP
    } t_ctrl_state;

    typedef enum logic [2:0] {
        XS_IDLE,
        XS_MUL_A,
        XS_MUL_B,
        XS_ABS,
        XS_DIV,
        XS_DONE
    } t_cross_state;

    typedef struct packed {
        logic       in_ready;
        logic       load_en;
        logic       step_en;
        logic       pre_en;
        logic [3:0] clip_idx;
        logic       cross_start;
        logic       apply_edge;
        logic       apply_cross;
        logic       post_en;
        logic       setup_en;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic clip_cond;
        logic clip_same;
        logic cross_done;
    } t_status;

    function automatic logic [DIM_BITS-1:0] canvas_dim(input logic [DIM_BITS-1:0] r);
        logic [DIM_BITS-1:0] d;
        d = r;
        if (r == '0) begin
            d = DIM_BITS'(1);
        end else if (r > DIM_BITS'(MAX_DIM)) begin
            d = DIM_BITS'(MAX_DIM);
        end
        return d;
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(input logic signed [CW-1:0] v,
                                                         input logic [DIM_BITS-1:0] lim);
        logic signed [CW-1:0] top;
        logic signed [CW-1:0] r;
        top = signed'({{(CW-DIM_BITS){1'b0}}, lim}) - CW'(1);
        r   = v;
        if (v < 0) begin
            r = '0;
        end else if (v > top) begin
            r = top;
        end
        return r;
    endfunction

endpackage

### rtl/core/clr_cross.sv
// Multi-cycle unit for trunc((diff*tn + base*td) / td), clamped to +-2^30.
module clr_cross import clr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_diff,
    input  logic signed [AW-1:0] i_tn,
    input  logic signed [AW-1:0] i_td,
    input  logic signed [AW-1:0] i_base,
    output logic                 o_done,
    output logic signed [CW-1:0] o_result
);

    t_cross_state r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] r_mc;
    logic [AW-1:0] r_mp;
    logic signed [AW-1:0] r_td;
    logic signed [AW-1:0] r_base;
    logic [QW-1:0] r_quo;
    logic [AW-1:0] r_rem;
    logic [AW-1:0] r_div;
    logic r_neg;

    logic signed [PW-1:0] addend;
    logic [PW-1:0] acc_mag;
    logic [AW-1:0] td_mag;
    logic [AW:0] trial;
    logic trial_ok;
    logic [CW-1:0] mag;
    logic mul_last;

    assign mul_last = r_cnt == CNT_BITS'(AW - 1);
    assign addend   = r_mp[0] ? r_mc : '0;
    assign acc_mag  = r_acc[PW-1] ? PW'(-r_acc) : PW'(r_acc);
    assign td_mag   = r_td[AW-1] ? AW'(-r_td) : AW'(r_td);
    assign trial    = {r_rem, r_quo[QW-1]};
    assign trial_ok = trial >= {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            XS_IDLE:  if (i_start) n_state = XS_MUL_A;
            XS_MUL_A: if (mul_last) n_state = XS_MUL_B;
            XS_MUL_B: if (mul_last) n_state = XS_ABS;
            XS_ABS:   n_state = XS_DIV;
            XS_DIV:   if (r_cnt == CNT_BITS'(QW - 1)) n_state = XS_DONE;
            XS_DONE:  n_state = XS_IDLE;
            default:  n_state = XS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= XS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            XS_IDLE: begin
                r_mc   <= PW'(i_diff);
                r_mp   <= i_tn;
                r_td   <= i_td;
                r_base <= i_base;
                r_acc  <= '0;
                r_cnt  <= '0;
            end
            XS_MUL_A, XS_MUL_B: begin
                // The top multiplier bit carries negative weight.
                if (mul_last) begin
                    r_acc <= r_acc - addend;
                    r_cnt <= '0;
                    r_mc  <= PW'(r_base);
                    r_mp  <= r_td;
                end else begin
                    r_acc <= r_acc + addend;
                    r_cnt <= r_cnt + CNT_BITS'(1);
                    r_mc  <= r_mc <<< 1;
                    r_mp  <= r_mp >> 1;
                end
            end
            XS_ABS: begin
                r_neg <= r_acc[PW-1] ^ r_td[AW-1];
                r_quo <= acc_mag[QW-1:0];
                r_div <= td_mag;
                r_rem <= '0;
                r_cnt <= '0;
            end
            XS_DIV: begin
                r_rem <= trial_ok ? AW'(trial - {1'b0, r_div}) : trial[AW-1:0];
                r_quo <= {r_quo[QW-2:0], trial_ok};
                r_cnt <= r_cnt + CNT_BITS'(1);
            end
            XS_DONE: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign mag      = (r_quo > QW'(LIMIT_MAG)) ? LIMIT_MAG : r_quo[CW-1:0];
    assign o_result = r_neg ? signed'(CW'(-mag)) : signed'(mag);
    assign o_done   = r_state == XS_DONE;

endmodule

### rtl/core/clr_ctrl.sv
// Controller state machine sequencing load, clipping, set-up and pixel steps.
module clr_ctrl import clr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_ctrl_state r_state, n_state;
    logic [3:0] r_clip_idx, n_clip_idx;
    logic clip_last;

    assign clip_last = r_clip_idx == LAST_CLIP;

    always_comb begin
        n_state    = r_state;
        n_clip_idx = r_clip_idx;
        o_cmd      = '0;
        o_cmd.clip_idx = r_clip_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.load_en = 1'b1;
                        n_state       = ST_PRE;
                    end else begin
                        o_cmd.step_en = 1'b1;
                    end
                end
            end
            ST_PRE: begin
                o_cmd.pre_en = 1'b1;
                n_clip_idx   = '0;
                n_state      = ST_CLIP_EVAL;
            end
            ST_CLIP_EVAL: begin
                if (i_status.clip_cond && !i_status.clip_same) begin
                    o_cmd.cross_start = 1'b1;
                    n_state           = ST_CLIP_WAIT;
                end else begin
                    o_cmd.apply_edge = i_status.clip_cond;
                    n_clip_idx       = r_clip_idx + 4'd1;
                    if (clip_last) n_state = ST_POST;
                end
            end
            ST_CLIP_WAIT: begin
                if (i_status.cross_done) begin
                    o_cmd.apply_cross = 1'b1;
                    n_clip_idx        = r_clip_idx + 4'd1;
                    n_state           = clip_last ? ST_POST : ST_CLIP_EVAL;
                end
            end
            ST_POST: begin
                o_cmd.post_en = 1'b1;
                n_state       = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup_en = 1'b1;
                n_state        = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clip_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_clip_idx <= n_clip_idx;
        end
    end

    a_cross_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cross_start |=> r_state == ST_CLIP_WAIT)
        else $error("clip division started without waiting for it");

    a_load_clips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_en && i_in_valid) |=> (r_state == ST_PRE && !o_cmd.in_ready))
        else $error("load transfer did not enter the clipping sequence");

endmodule

### rtl/core/clr_dp.sv
// Datapath: canvas registers, endpoint clipping, Bresenham state and output register.
module clr_dp import clr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    output t_status                      o_status,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [DIM_BITS-1:0]          i_cfg_data,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0]        i_line_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [POS_BITS-1:0]          o_pixel_x,
    output logic [POS_BITS-1:0]          o_pixel_y,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_last_pixel
);

    logic [DIM_BITS-1:0] r_canvas_w, r_canvas_h;
    logic signed [CW-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [COLOR_BITS-1:0] r_color;
    logic r_drawing, r_steep, r_major_neg, r_minor_neg;
    logic [DIM_BITS-1:0] r_major_pos, r_major_end, r_minor_pos;
    logic signed [ERR_BITS-1:0] r_err, r_step_mv;
    logic [SNM_BITS-1:0] r_step_nm;
    logic r_out_valid, r_last;
    logic [POS_BITS-1:0] r_px, r_py;
    logic [COLOR_BITS-1:0] r_pc;

    logic [DIM_BITS-1:0] w, h;
    logic signed [CW-1:0] wext, hext, limext, edge_val;
    logic signed [CW-1:0] a0, a1, b0, b1, a_sel;
    logic axis, end1, high;
    logic signed [AW-1:0] c_diff, c_tn, c_td, c_base;
    logic cross_done;
    logic signed [CW-1:0] cross_res;

    assign w      = canvas_dim(r_canvas_w);
    assign h      = canvas_dim(r_canvas_h);
    assign wext   = signed'({{(CW-DIM_BITS){1'b0}}, w});
    assign hext   = signed'({{(CW-DIM_BITS){1'b0}}, h});

    // Clip order per pass: x1 high, x1 low, x0 high, x0 low, then the same for y.
    assign axis   = i_cmd.clip_idx[2];
    assign end1   = !i_cmd.clip_idx[1];
    assign high   = !i_cmd.clip_idx[0];
    assign a0     = axis ? r_y0 : r_x0;
    assign a1     = axis ? r_y1 : r_x1;
    assign b0     = axis ? r_x0 : r_y0;
    assign b1     = axis ? r_x1 : r_y1;
    assign limext = axis ? hext : wext;
    assign a_sel  = end1 ? a1 : a0;
    assign edge_val = high ? limext - CW'(1) : '0;

    assign c_diff = AW'(b1) - AW'(b0);
    assign c_tn   = (high ? AW'(limext) : '0) - AW'(a0);
    assign c_td   = AW'(a1) - AW'(a0);
    assign c_base = AW'(b0);

    clr_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.cross_start),
        .i_diff   (c_diff),
        .i_tn     (c_tn),
        .i_td     (c_td),
        .i_base   (c_base),
        .o_done   (cross_done),
        .o_result (cross_res)
    );

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.clip_cond  = high ? (a_sel >= limext) : (a_sel <= 0);
    assign o_status.clip_same  = a1 == a0;
    assign o_status.cross_done = cross_done;

    // Line set-up from the clamped endpoints.
    logic [DIM_BITS-1:0] sx0, sy0, sx1, sy1, maj0, maj1, min0, min1;
    logic signed [DIM_BITS:0] dx, dy, dmaj, dmin;
    logic [DIM_BITS-1:0] adx, ady, amaj, amin;
    logic steep;

    assign sx0  = r_x0[DIM_BITS-1:0];
    assign sy0  = r_y0[DIM_BITS-1:0];
    assign sx1  = r_x1[DIM_BITS-1:0];
    assign sy1  = r_y1[DIM_BITS-1:0];
    assign dx   = signed'({1'b0, sx1}) - signed'({1'b0, sx0});
    assign dy   = signed'({1'b0, sy1}) - signed'({1'b0, sy0});
    assign adx  = dx[DIM_BITS] ? DIM_BITS'(-dx) : dx[DIM_BITS-1:0];
    assign ady  = dy[DIM_BITS] ? DIM_BITS'(-dy) : dy[DIM_BITS-1:0];
    assign steep = ady >= adx;
    assign maj0 = steep ? sy0 : sx0;
    assign maj1 = steep ? sy1 : sx1;
    assign min0 = steep ? sx0 : sy0;
    assign min1 = steep ? sx1 : sy1;
    assign dmaj = signed'({1'b0, maj1}) - signed'({1'b0, maj0});
    assign dmin = signed'({1'b0, min1}) - signed'({1'b0, min0});
    assign amaj = dmaj[DIM_BITS] ? DIM_BITS'(-dmaj) : dmaj[DIM_BITS-1:0];
    assign amin = dmin[DIM_BITS] ? DIM_BITS'(-dmin) : dmin[DIM_BITS-1:0];

    // Pixel step.
    logic [DIM_BITS-1:0] px_raw, py_raw, px_c, py_c, n_major, n_minor;
    logic signed [ERR_BITS-1:0] n_err;
    logic n_last;

    assign px_raw = r_steep ? r_minor_pos : r_major_pos;
    assign py_raw = r_steep ? r_major_pos : r_minor_pos;
    assign px_c   = (px_raw > w - DIM_BITS'(1)) ? w - DIM_BITS'(1) : px_raw;
    assign py_c   = (py_raw > h - DIM_BITS'(1)) ? h - DIM_BITS'(1) : py_raw;
    assign n_major = r_major_neg ? r_major_pos - DIM_BITS'(1) : r_major_pos + DIM_BITS'(1);
    assign n_minor = (r_err > 0) ?
                     (r_minor_neg ? r_minor_pos - DIM_BITS'(1) : r_minor_pos + DIM_BITS'(1)) :
                     r_minor_pos;
    assign n_err  = r_err + ((r_err > 0) ? r_step_mv : signed'({1'b0, r_step_nm}));
    assign n_last = n_major == r_major_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= RESET_WIDTH;
            r_canvas_h <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_CANVAS_WIDTH) begin
                r_canvas_w <= i_cfg_data;
            end else begin
                r_canvas_h <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_en) begin
            r_x0    <= CW'(i_start_x);
            r_y0    <= CW'(i_start_y);
            r_x1    <= CW'(i_end_x);
            r_y1    <= CW'(i_end_y);
            r_color <= i_line_color;
        end else if (i_cmd.pre_en) begin
            // Endpoints wholly beyond one edge move onto it.
            if (r_x0 <= 0 && r_x1 <= 0) begin
                r_x0 <= '0;
                r_x1 <= '0;
            end else if (r_x0 >= wext && r_x1 >= wext) begin
                r_x0 <= wext - CW'(1);
                r_x1 <= wext - CW'(1);
            end
            if (r_y0 <= 0 && r_y1 <= 0) begin
                r_y0 <= '0;
                r_y1 <= '0;
            end else if (r_y0 >= hext && r_y1 >= hext) begin
                r_y0 <= hext - CW'(1);
                r_y1 <= hext - CW'(1);
            end
        end else if (i_cmd.apply_edge || i_cmd.apply_cross) begin
            unique case ({axis, end1})
                2'b01: begin
                    r_x1 <= edge_val;
                    if (i_cmd.apply_cross) r_y1 <= cross_res;
                end
                2'b00: begin
                    r_x0 <= edge_val;
                    if (i_cmd.apply_cross) r_y0 <= cross_res;
                end
                2'b11: begin
                    r_y1 <= edge_val;
                    if (i_cmd.apply_cross) r_x1 <= cross_res;
                end
                default: begin
                    r_y0 <= edge_val;
                    if (i_cmd.apply_cross) r_x0 <= cross_res;
                end
            endcase
        end else if (i_cmd.post_en) begin
            r_x0 <= clamp_coord(r_x0, w);
            r_x1 <= clamp_coord(r_x1, w);
            r_y0 <= clamp_coord(r_y0, h);
            r_y1 <= clamp_coord(r_y1, h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing <= 1'b0;
        end else if (i_cmd.setup_en) begin
            r_drawing <= amaj != '0;
        end else if (i_cmd.step_en && r_drawing) begin
            r_drawing <= !n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup_en) begin
            r_steep     <= steep;
            r_major_neg <= dmaj[DIM_BITS];
            r_minor_neg <= dmin[DIM_BITS];
            r_major_pos <= maj0;
            r_major_end <= maj1;
            r_minor_pos <= min0;
            r_step_nm   <= {1'b0, amin, 1'b0};
            r_step_mv   <= signed'({2'b0, amin, 1'b0}) - signed'({2'b0, amaj, 1'b0});
            r_err       <= signed'({2'b0, amin, 1'b0}) - signed'({3'b0, amaj});
        end else if (i_cmd.step_en && r_drawing) begin
            r_major_pos <= n_major;
            r_minor_pos <= n_minor;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step_en && r_drawing) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_en && r_drawing) begin
            r_px   <= px_c[POS_BITS-1:0];
            r_py   <= py_c[POS_BITS-1:0];
            r_pc   <= r_color;
            r_last <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pc;
    assign o_last_pixel  = r_last;

    a_drawing_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawing |-> r_major_pos != r_major_end)
        else $error("line in progress already sits on its excluded end point");

    a_step_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step_en && r_drawing) |=> r_out_valid)
        else $error("pixel step on a live line produced no result");

endmodule

### rtl/core/clipped_line_rasterizer.sv
// Clipped line rasteriser top level.
// Input channel (i_in_valid / o_in_ready): an operation of load carries two
// signed endpoints and a colour; an operation of step asks for the next pixel.
// Output channel (o_out_valid / i_out_ready): one pixel per step transfer on a
// live line, with last_pixel set on the final one; the end point is not drawn.
// A step on no live line is taken and yields nothing.
// A step result is in the output register in the cycle after its transfer, and
// a step can be taken every cycle while the receiver keeps up.
// A load takes the block away from the input through the pre-clip, edge-clip,
// post-clip and set-up states; each edge clip that needs a new crossing point
// (at most sixteen) also waits on the crossing multiply and divide, which run
// a bit at a time in one shared unit.
// When the receiver stalls, the pending pixel stays in the output register and
// no further transfer is taken until it has gone. Reset (synchronous, active
// low) ends any line and sets the canvas to 1024 by 768. Canvas registers are
// to be written via i_cfg_we only while idle; the block does not enforce it.
module clipped_line_rasterizer import clr_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_operation,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic [COLOR_BITS-1:0]        i_line_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [POS_BITS-1:0]          o_pixel_x,
    output logic [POS_BITS-1:0]          o_pixel_y,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_last_pixel,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [DIM_BITS-1:0]          i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    clr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    clr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_line_color  (i_line_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    assign o_in_ready = cmd.in_ready;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the clipped line rasteriser: load, clip and step checks.
module testbench;
    import clr_pkg::*;

    typedef struct packed {
        logic                  op;
        logic signed [15:0]    sx;
        logic signed [15:0]    sy;
        logic signed [15:0]    ex;
        logic signed [15:0]    ey;
        logic [COLOR_BITS-1:0] color;
    } t_cmd_item;

    typedef struct packed {
        logic [POS_BITS-1:0]   px;
        logic [POS_BITS-1:0]   py;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } t_pixel;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic                         i_operation = OP_STEP;
    logic signed [COORD_BITS-1:0] i_start_x = '0;
    logic signed [COORD_BITS-1:0] i_start_y = '0;
    logic signed [COORD_BITS-1:0] i_end_x = '0;
    logic signed [COORD_BITS-1:0] i_end_y = '0;
    logic [COLOR_BITS-1:0]        i_line_color = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [POS_BITS-1:0]          o_pixel_x;
    logic [POS_BITS-1:0]          o_pixel_y;
    logic [COLOR_BITS-1:0]        o_pixel_color;
    logic                         o_last_pixel;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_index = REG_CANVAS_WIDTH;
    logic [DIM_BITS-1:0]          i_cfg_data = '0;

    clipped_line_rasterizer dut (.*);

    always #10 i_clk = ~i_clk;

    // Predictor state.
    longint    canvas_w, canvas_h;
    bit        line_live, steep;
    longint    maj_pos, maj_end, min_pos, err, inc_flat, inc_diag;
    bit        maj_neg, min_neg;
    logic [23:0] line_rgb;

    t_cmd_item pending_cmds[$];
    t_pixel    expected_pixels[$];
    int        mismatches = 0;
    int        pixels_seen = 0;
    int        loads_sent = 0;
    bit        calm = 0;        // no idling in the final part
    bit        hold_off = 0;    // long receiver stall
    bit        stall_req = 0;
    bit        stall_done = 0;
    int        in_gap = 0, out_gap = 0;

    function automatic longint dim_of(longint r);
        if (r == 0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return r;
    endfunction

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // trunc(base + diff*tn/td), exact, clamped to +-2^30
    function automatic longint crossing(longint diff, longint tn, longint td, longint base);
        longint num;
        num = diff * tn + base * td;
        return clampv(num / td, -(64'sd1 << 30), 64'sd1 << 30);
    endfunction

    task automatic clip_pair(inout longint a0, inout longint b0, inout longint a1,
                             inout longint b1, input longint lim);
        if (a1 >= lim) begin
            if (a1 != a0) b1 = crossing(b1 - b0, lim - a0, a1 - a0, b0);
            a1 = lim - 1;
        end
        if (a1 <= 0) begin
            if (a1 != a0) b1 = crossing(b1 - b0, -a0, a1 - a0, b0);
            a1 = 0;
        end
        if (a0 >= lim) begin
            if (a1 != a0) b0 = crossing(b1 - b0, lim - a0, a1 - a0, b0);
            a0 = lim - 1;
        end
        if (a0 <= 0) begin
            if (a1 != a0) b0 = crossing(b1 - b0, -a0, a1 - a0, b0);
            a0 = 0;
        end
    endtask

    task automatic predict_raster(input t_cmd_item c);
        longint w, h, x0, y0, x1, y1, dx, dy, t, px, py;
        t_pixel p;
        w = dim_of(canvas_w);
        h = dim_of(canvas_h);
        if (c.op == OP_LOAD) begin
            x0 = c.sx; y0 = c.sy; x1 = c.ex; y1 = c.ey;
            if (x0 <= 0 && x1 <= 0) begin x0 = 0; x1 = 0; end
            if (x0 >= w && x1 >= w) begin x0 = w - 1; x1 = w - 1; end
            if (y0 <= 0 && y1 <= 0) begin y0 = 0; y1 = 0; end
            if (y0 >= h && y1 >= h) begin y0 = h - 1; y1 = h - 1; end
            for (int k = 0; k < 2; k++) begin
                clip_pair(x0, y0, x1, y1, w);
                clip_pair(y0, x0, y1, x1, h);
            end
            x0 = clampv(x0, 0, w - 1); x1 = clampv(x1, 0, w - 1);
            y0 = clampv(y0, 0, h - 1); y1 = clampv(y1, 0, h - 1);
            dx = x1 - x0; dy = y1 - y0;
            steep = (dy < 0 ? -dy : dy) >= (dx < 0 ? -dx : dx);
            if (steep) begin
                t = x0; x0 = y0; y0 = t;
                t = x1; x1 = y1; y1 = t;
                dx = x1 - x0; dy = y1 - y0;
            end
            maj_neg = dx < 0; if (dx < 0) dx = -dx;
            min_neg = dy < 0; if (dy < 0) dy = -dy;
            inc_flat = 2 * dy; inc_diag = 2 * dy - 2 * dx; err = 2 * dy - dx;
            maj_pos = x0; maj_end = x1; min_pos = y0;
            line_rgb = c.color;
            line_live = dx != 0;
        end else if (line_live) begin
            px = clampv(steep ? min_pos : maj_pos, 0, w - 1);
            py = clampv(steep ? maj_pos : min_pos, 0, h - 1);
            if (err > 0) begin
                err += inc_diag;
                min_pos += min_neg ? -1 : 1;
            end else begin
                err += inc_flat;
            end
            maj_pos += maj_neg ? -1 : 1;
            p.px = px[11:0]; p.py = py[11:0]; p.color = line_rgb;
            p.last = maj_pos == maj_end;
            if (p.last) line_live = 0;
            expected_pixels.push_back(p);
        end
    endtask

    // Driver: offers queued commands and predicts each on its transfer.
    logic o_in_ready_q;
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_raster('{i_operation, i_start_x, i_start_y, i_end_x, i_end_y,
                             i_line_color});
            if (i_operation == OP_LOAD) loads_sent++;
        end
        o_in_ready_q <= i_in_valid && o_in_ready;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready_q) begin
                // still waiting for the transfer
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 14) == 0) begin
                in_gap = $urandom_range(1, 10);
                i_in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                t_cmd_item c;
                c = pending_cmds.pop_front();
                i_in_valid   <= 1'b1;
                i_operation  <= c.op;
                i_start_x    <= c.sx;
                i_start_y    <= c.sy;
                i_end_x      <= c.ex;
                i_end_y      <= c.ey;
                i_line_color <= c.color;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver readiness.
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_gap = $urandom_range(1, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Long receiver stall, timed here while the sender keeps offering items.
    initial begin
        wait (stall_req);
        hold_off = 1;
        repeat (3000) @(posedge i_clk);
        hold_off = 0;
        stall_done = 1;
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_pixel got, want;
            got = '{o_pixel_x, o_pixel_y, o_pixel_color, o_last_pixel};
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: expected none, got x=%0d y=%0d c=%h last=%0d",
                             got.px, got.py, got.color, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: expected x=%0d y=%0d c=%h last=%0d,",
                                  " got x=%0d y=%0d c=%h last=%0d"},
                                 want.px, want.py, want.color, want.last,
                                 got.px, got.py, got.color, got.last);
                end
            end
        end
    end

    task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
        t_cmd_item c;
        c = '{OP_LOAD, 16'(sx), 16'(sy), 16'(ex), 16'(ey), 24'($urandom)};
        pending_cmds.push_back(c);
        c.op = OP_STEP;
        repeat (steps) pending_cmds.push_back(c);
    endtask

    function automatic int rand_coord(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return int'(16'($urandom));
        if (r == 1) return $urandom_range(0, 1) ? 32767 : -32768;
        return $urandom_range(0, span + 40) - 20;
    endfunction

    task automatic drain_and_settle();
        while (pending_cmds.size() > 0 || i_in_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
    endtask

    task automatic write_canvas(input logic idx, input int v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= DIM_BITS'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_CANVAS_WIDTH) canvas_w = v & 16'h1FFF;
        else canvas_h = v & 16'h1FFF;
    endtask

    initial begin
        canvas_w = 1024; canvas_h = 768;
        line_live = 0; steep = 0; line_rgb = 0;
        maj_pos = 0; maj_end = 0; min_pos = 0; err = 0; inc_flat = 0; inc_diag = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: step while idle, degenerate, extremes, steep, reversed, replace.
        begin
            t_cmd_item s;
            s = '{OP_STEP, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0, 24'hFFFFFF};
            pending_cmds.push_back(s);
        end
        add_line(5, 5, 5, 5, 2);
        add_line(-32768, -32768, 32767, 32767, 6);
        add_line(32767, -100, -32768, 900, 4);
        add_line(10, 3, 13, 20, 18);
        add_line(40, 30, 20, 28, 22);
        add_line(-5, 100, -9, 300, 1);
        add_line(2000, 800, 1500, 900, 3);
        add_line(0, 0, 6, 2, 3);
        drain_and_settle();

        // Canvas settings: reset values, then extremes, out-of-range codes and small sizes.
        for (int phase = 0; phase < 6; phase++) begin
            int wv, hv;
            case (phase)
                0: begin wv = 1024; hv = 768; end
                1: begin wv = 1; hv = 1; end
                2: begin wv = 0; hv = 8191; end
                3: begin wv = 4096; hv = 4096; end
                4: begin wv = 37; hv = 23; end
                default: begin wv = 160; hv = 120; end
            endcase
            write_canvas(REG_CANVAS_WIDTH, wv);
            write_canvas(REG_CANVAS_HEIGHT, hv);
            for (int n = 0; n < 6; n++) begin
                int span;
                span = (dim_of(canvas_w) > 200) ? 200 : int'(dim_of(canvas_w));
                if ($urandom_range(0, 3) == 0)
                    add_line(rand_coord(span), rand_coord(span), rand_coord(span),
                             rand_coord(span), $urandom_range(0, 12));
                else
                    add_line($urandom_range(0, span), $urandom_range(0, span),
                             $urandom_range(0, span), $urandom_range(0, span),
                             $urandom_range(5, 30));
            end
            if (phase == 3) begin
                // Stall the receiver long enough for the input to back up.
                stall_req = 1;
                wait (stall_done);
            end
            if (phase == 5) calm = 1;
            drain_and_settle();
        end

        $display("covered %0d loads and %0d pixels over six canvas settings",
                 loads_sent, pixels_seen);
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("clipped_line_rasterizer test passed");
        end else begin
            $display("clipped_line_rasterizer test failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("clipped_line_rasterizer test failed");
        $finish;
    end
endmodule

### files.f
rtl/core/clr_pkg.sv
rtl/core/clr_cross.sv
rtl/core/clr_ctrl.sv
rtl/core/clr_dp.sv
rtl/core/clipped_line_rasterizer.sv
tb/sv/testbench.sv
